// ===== hw/rtl/ism_pkg.sv =====
package ism_pkg;

    typedef enum logic [5:0] {
        OP_NOP = 6'd0, OP_HALT = 6'd1, OP_PUSH = 6'd2, OP_POP = 6'd3, OP_DUP = 6'd4,
        OP_JMP = 6'd5, OP_JMP_IF = 6'd6, OP_EQ = 6'd7, OP_NEQ = 6'd8, OP_LT = 6'd9,
        OP_GT = 6'd10, OP_LE = 6'd11, OP_GE = 6'd12, OP_MOV_REG = 6'd13,
        OP_LOAD_REG = 6'd14, OP_ADD = 6'd15, OP_SUB = 6'd16, OP_MUL = 6'd17,
        OP_DIV = 6'd18, OP_INC = 6'd19, OP_MOD = 6'd20, OP_POW = 6'd21, OP_ABS = 6'd22,
        OP_MIN = 6'd23, OP_MAX = 6'd24, OP_AND = 6'd25, OP_OR = 6'd26, OP_XOR = 6'd27,
        OP_NOT = 6'd28, OP_SHL = 6'd29, OP_SHR = 6'd30, OP_CALL = 6'd31, OP_RET = 6'd32
    } t_op;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0, ERR_UNDERFLOW = 3'd1, ERR_OVERFLOW = 3'd2,
        ERR_DIV_ZERO = 3'd3, ERR_MOD_ZERO = 3'd4, ERR_RET_OVERFLOW = 3'd5
    } t_err;

    typedef enum logic [1:0] {I_MUL, I_DIV, I_MOD, I_POW} t_iop;

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_DONE} t_ustate;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EVAL, S_ITER, S_FIN} t_state;

    typedef struct packed {
        logic latch;
        logic start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic iter;
        logic done;
        logic out_free;
    } t_status;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

// ===== hw/rtl/ism_ram.sv =====
module ism_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/ism_iter.sv =====
module ism_iter import ism_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_iop        i_op,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_result
);
    t_ustate r_state, n_state;
    t_iop    r_op, n_op;
    logic [63:0] r_x, n_x, r_y, n_y, r_acc, n_acc;
    logic [1:0]  r_k, n_k;
    logic [63:0] r_pr, n_pr, r_pb, n_pb, r_pe, n_pe;
    logic        r_phase, n_phase;
    logic [63:0] r_rem, n_rem, r_quo, n_quo, r_ub, n_ub, r_res, n_res;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_nq, n_nq, r_nr, n_nr;

    logic [63:0] prod, mulres, pe_sh;
    logic [64:0] trial;
    logic        ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op <= n_op; r_x <= n_x; r_y <= n_y; r_acc <= n_acc; r_k <= n_k;
        r_pr <= n_pr; r_pb <= n_pb; r_pe <= n_pe; r_phase <= n_phase;
        r_rem <= n_rem; r_quo <= n_quo; r_ub <= n_ub; r_res <= n_res;
        r_cnt <= n_cnt; r_nq <= n_nq; r_nr <= n_nr;
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_x = r_x; n_y = r_y; n_acc = r_acc; n_k = r_k;
        n_pr = r_pr; n_pb = r_pb; n_pe = r_pe; n_phase = r_phase;
        n_rem = r_rem; n_quo = r_quo; n_ub = r_ub; n_res = r_res;
        n_cnt = r_cnt; n_nq = r_nq; n_nr = r_nr;

        // one 16-bit digit of the multiplier per cycle
        prod   = r_x * {48'd0, r_y[{r_k, 4'd0} +: 16]};
        mulres = r_acc + (prod << {r_k, 4'd0});
        pe_sh  = r_pe >> 1;
        trial  = {r_rem, r_quo[63]};
        ge     = trial >= {1'b0, r_ub};

        case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    n_op  = i_op;
                    n_acc = 64'd0;
                    n_k   = 2'd0;
                    case (i_op)
                        I_MUL: begin
                            n_x = i_a; n_y = i_b; n_state = U_MUL;
                        end
                        I_POW: begin
                            if (i_b[63] || i_b == 64'd0) begin
                                n_res = 64'd1; n_state = U_DONE;
                            end else begin
                                n_pr = 64'd1; n_pb = i_a; n_pe = i_b;
                                n_phase = !i_b[0];
                                n_x = i_b[0] ? 64'd1 : i_a;
                                n_y = i_a;
                                n_state = U_MUL;
                            end
                        end
                        default: begin
                            n_ub = mag64(i_b); n_quo = mag64(i_a); n_rem = 64'd0;
                            n_cnt = 6'd0; n_nq = i_a[63] ^ i_b[63]; n_nr = i_a[63];
                            n_state = U_DIV;
                        end
                    endcase
                end
            end
            U_MUL: begin
                n_acc = mulres;
                n_k   = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_acc = 64'd0;
                    if (r_op == I_MUL) begin
                        n_res = mulres; n_state = U_DONE;
                    end else if (!r_phase) begin
                        // result times base done, now square the base
                        n_pr = mulres; n_phase = 1'b1; n_x = r_pb; n_y = r_pb;
                    end else begin
                        n_pb = mulres;
                        n_pe = pe_sh;
                        if (pe_sh == 64'd0) begin
                            n_res = r_pr; n_state = U_DONE;
                        end else if (pe_sh[0]) begin
                            n_phase = 1'b0; n_x = r_pr; n_y = mulres;
                        end else begin
                            n_phase = 1'b1; n_x = mulres; n_y = mulres;
                        end
                    end
                end
            end
            U_DIV: begin
                n_rem = ge ? 64'(trial - {1'b0, r_ub}) : trial[63:0];
                n_quo = {r_quo[62:0], ge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    if (r_op == I_DIV) begin
                        n_res = r_nq ? (64'd0 - n_quo) : n_quo;
                    end else begin
                        n_res = r_nr ? (64'd0 - n_rem) : n_rem;
                    end
                    n_state = U_DONE;
                end
            end
            U_DONE: n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    assign o_done   = (r_state == U_DONE);
    assign o_result = r_res;
endmodule

// ===== hw/rtl/ism_datapath.sv =====
module ism_datapath import ism_pkg::*; #(
    parameter int STACK_DEPTH    = 64,
    parameter int RETURN_DEPTH   = 16,
    parameter int NUM_REGS       = 16,
    parameter int PROG_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [5:0]  i_func,
    input  logic [7:0]  i_reg_index,
    input  logic [63:0] i_operand,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [15:0] o_next_ip,
    output logic        o_running,
    output logic [63:0] o_top_value,
    output logic        o_top_valid,
    output logic [2:0]  o_error_code
);
    localparam int SB  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int RTB = $clog2(RETURN_DEPTH);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);
    localparam int RB  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int PB  = PROG_ADDR_BITS;

    logic [5:0]  r_func;
    logic [7:0]  r_ri;
    logic [63:0] r_opd;
    logic [63:0] r_tos, n_tos;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [RCW-1:0] r_rc, n_rc;
    logic [PB-1:0]  r_pc, n_pc;
    logic           r_halt, n_halt;
    logic [NUM_REGS-1:0] r_rvalid, n_rvalid;
    logic        r_ovalid;
    logic [15:0] r_o_nip;
    logic        r_o_run, r_o_tv;
    logic [63:0] r_o_top;
    logic [2:0]  r_o_err;

    logic [63:0] stk_rd, reg_rd;
    logic [PB-1:0] ret_rd;
    logic          stk_we, reg_we, ret_we;
    logic [63:0]   stk_wd;
    logic [PB-1:0] ret_wd;

    logic [1:0]  need;
    logic        grow, reg_ok, is_iter, lt_ab, lt_ba, sh_big;
    t_err        err;
    t_iop        iop;
    logic [63:0] a, b, r, reg_val, iter_res;
    logic [PB-1:0] nip, target;
    logic        run, iter_done;

    ism_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(SB'(r_cnt - CW'(1))), .i_wdata(stk_wd),
        .i_raddr(SB'(r_cnt - CW'(2))), .o_rdata(stk_rd)
    );

    ism_ram #(.WIDTH(64), .DEPTH((NUM_REGS > 1) ? NUM_REGS : 2)) u_regs (
        .i_clk(i_clk), .i_we(reg_we), .i_waddr(r_ri[RB-1:0]), .i_wdata(r_tos),
        .i_raddr(r_ri[RB-1:0]), .o_rdata(reg_rd)
    );

    ism_ram #(.WIDTH(PB), .DEPTH(RETURN_DEPTH)) u_ret (
        .i_clk(i_clk), .i_we(ret_we), .i_waddr(RTB'(r_rc)), .i_wdata(ret_wd),
        .i_raddr(RTB'(r_rc - RCW'(1))), .o_rdata(ret_rd)
    );

    ism_iter u_iter (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.start), .i_op(iop),
        .i_a(a), .i_b(b), .o_done(iter_done), .o_result(iter_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rc     <= '0;
            r_pc     <= '0;
            r_halt   <= 1'b0;
            r_rvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_rc     <= n_rc;
            r_pc     <= n_pc;
            r_halt   <= n_halt;
            r_rvalid <= n_rvalid;
            if (i_cmd.commit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        r_tos <= n_tos;
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_ri   <= i_reg_index;
            r_opd  <= i_operand;
        end
        if (i_cmd.commit) begin
            r_o_nip <= 16'(nip);
            r_o_run <= run;
            r_o_top <= (n_cnt != '0) ? n_tos : 64'd0;
            r_o_tv  <= (n_cnt != '0);
            r_o_err <= err;
        end
    end

    always_comb begin
        need = 2'd0;
        grow = 1'b0;
        reg_ok = ({24'd0, r_ri} < NUM_REGS);
        case (r_func)
            OP_PUSH: grow = 1'b1;
            OP_POP, OP_JMP_IF, OP_INC, OP_ABS, OP_NOT: need = 2'd1;
            OP_DUP: begin
                need = 2'd1; grow = 1'b1;
            end
            OP_MOV_REG: need = reg_ok ? 2'd1 : 2'd0;
            OP_LOAD_REG: grow = reg_ok;
            OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LE, OP_GE, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
            OP_MOD, OP_POW, OP_MIN, OP_MAX, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
                need = 2'd2;
            default: need = 2'd0;
        endcase

        b = r_tos;
        a = (need == 2'd2) ? stk_rd : r_tos;
        reg_val = r_rvalid[r_ri[RB-1:0]] ? reg_rd : 64'd0;

        err = ERR_NONE;
        if (r_cnt < CW'(need)) begin
            err = ERR_UNDERFLOW;
        end else if (grow && ({1'b0, r_cnt} >= (CW + 1)'(STACK_DEPTH))) begin
            err = ERR_OVERFLOW;
        end else if (r_func == OP_DIV && b == 64'd0) begin
            err = ERR_DIV_ZERO;
        end else if (r_func == OP_MOD && b == 64'd0) begin
            err = ERR_MOD_ZERO;
        end else if (r_func == OP_CALL && ({1'b0, r_rc} >= (RCW + 1)'(RETURN_DEPTH))) begin
            err = ERR_RET_OVERFLOW;
        end

        case (r_func)
            OP_MUL:  iop = I_MUL;
            OP_DIV:  iop = I_DIV;
            OP_MOD:  iop = I_MOD;
            default: iop = I_POW;
        endcase
        is_iter = (r_func == OP_MUL || r_func == OP_DIV || r_func == OP_MOD
                   || r_func == OP_POW);

        lt_ab  = $signed(a) < $signed(b);
        lt_ba  = $signed(b) < $signed(a);
        sh_big = (b[63:6] != 58'd0);
        case (r_func)
            OP_EQ:   r = {63'd0, a == b};
            OP_NEQ:  r = {63'd0, a != b};
            OP_LT:   r = {63'd0, lt_ab};
            OP_GT:   r = {63'd0, lt_ba};
            OP_LE:   r = {63'd0, !lt_ba};
            OP_GE:   r = {63'd0, !lt_ab};
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MIN:  r = lt_ba ? b : a;
            OP_MAX:  r = lt_ab ? b : a;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_SHL:  r = sh_big ? 64'd0 : (a << b[5:0]);
            OP_SHR:  r = sh_big ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
            default: r = iter_res;
        endcase

        target = r_opd[PB-1:0];
        nip    = r_pc + PB'(1);
        run    = 1'b1;
        n_tos = r_tos; n_cnt = r_cnt; n_rc = r_rc; n_pc = r_pc; n_halt = r_halt;
        n_rvalid = r_rvalid;
        stk_we = 1'b0; stk_wd = r_tos; reg_we = 1'b0; ret_we = 1'b0; ret_wd = nip;

        if (r_halt) begin
            nip = r_pc; run = 1'b0; err = ERR_NONE;
        end else if (err != ERR_NONE) begin
            nip = r_pc; run = 1'b0;
            if (i_cmd.commit) n_halt = 1'b1;
        end else begin
            if (need == 2'd2) begin
                n_tos = r; n_cnt = r_cnt - CW'(1);
            end else begin
                case (r_func)
                    OP_HALT: begin
                        run = 1'b0; n_halt = i_cmd.commit;
                    end
                    OP_PUSH: begin
                        stk_we = (r_cnt != '0); n_tos = r_opd; n_cnt = r_cnt + CW'(1);
                    end
                    OP_DUP: begin
                        stk_we = 1'b1; n_cnt = r_cnt + CW'(1);
                    end
                    OP_LOAD_REG: begin
                        if (reg_ok) begin
                            stk_we = (r_cnt != '0); n_tos = reg_val; n_cnt = r_cnt + CW'(1);
                        end
                    end
                    OP_POP: begin
                        n_tos = stk_rd; n_cnt = r_cnt - CW'(1);
                    end
                    OP_JMP: nip = target;
                    OP_JMP_IF: begin
                        n_tos = stk_rd; n_cnt = r_cnt - CW'(1);
                        if (a != 64'd0) nip = target;
                    end
                    OP_MOV_REG: begin
                        if (reg_ok) begin
                            reg_we = 1'b1; n_rvalid[r_ri[RB-1:0]] = 1'b1;
                            n_tos = stk_rd; n_cnt = r_cnt - CW'(1);
                        end
                    end
                    OP_INC: n_tos = a + 64'd1;
                    OP_ABS: n_tos = mag64(a);
                    OP_NOT: n_tos = ~a;
                    OP_CALL: begin
                        ret_we = 1'b1; n_rc = r_rc + RCW'(1); nip = target;
                    end
                    OP_RET: begin
                        if (r_rc == '0) begin
                            run = 1'b0; n_halt = i_cmd.commit;
                        end else begin
                            nip = ret_rd; n_rc = r_rc - RCW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            n_pc = nip;
        end

        // nothing moves except on the commit cycle
        if (!i_cmd.commit) begin
            n_tos = r_tos; n_cnt = r_cnt; n_rc = r_rc; n_pc = r_pc; n_halt = r_halt;
            n_rvalid = r_rvalid; stk_we = 1'b0; reg_we = 1'b0; ret_we = 1'b0;
        end
    end

    assign o_status.iter     = is_iter && !r_halt && (err == ERR_NONE);
    assign o_status.done     = iter_done;
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid  = r_ovalid;
    assign o_next_ip    = r_o_nip;
    assign o_running    = r_o_run;
    assign o_top_value  = r_o_top;
    assign o_top_valid  = r_o_tv;
    assign o_error_code = r_o_err;
endmodule

// ===== hw/rtl/ism_ctrl.sv =====
module ism_ctrl import ism_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_READ;
                end
            end
            // memories answer in the cycle after the address settles
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (i_status.iter) begin
                    o_cmd.start = 1'b1;
                    n_state = S_ITER;
                end else if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ITER: begin
                if (i_status.done) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/integer_stack_machine_execute.sv =====
// 64-bit integer stack machine, one instruction per request, one result per
// request. A simple instruction passes through accept, memory read and execute,
// and its result is registered at execute. MUL adds four digits of the 64x16
// multiplier, then done and finish; DIV and MOD add the 64 steps of the
// bit-serial divider, then done and finish; POW adds done and finish plus,
// through the same multiplier, a squaring per exponent bit up to the highest
// set bit and a multiply per set bit; with an exponent of zero or below it adds only done and finish.
// The top of the value stack sits in a register and the rest in a
// single-port-write memory, so every step reads at most one stored entry. The
// result register lets a finished result wait while the next request is taken.
// Errors, HALT and RET with an empty return stack stop the machine until reset.
module integer_stack_machine_execute import ism_pkg::*; #(
    parameter int STACK_DEPTH    = 64,
    parameter int RETURN_DEPTH   = 16,
    parameter int NUM_REGS       = 16,
    parameter int PROG_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[5:0], reg_index[13:6], operand[77:14], zero[79:78]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_ip[15:0], running[16], top_value[80:17], top_valid[81],
    // error_code[84:82], zero[87:85]
    output logic [87:0] m_axis_tdata
);
    t_cmd    cmd;
    t_status status;
    logic [15:0] next_ip;
    logic        running, top_valid;
    logic [63:0] top_value;
    logic [2:0]  error_code;

    ism_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_status(status), .o_cmd(cmd)
    );

    ism_datapath #(
        .STACK_DEPTH(STACK_DEPTH), .RETURN_DEPTH(RETURN_DEPTH),
        .NUM_REGS(NUM_REGS), .PROG_ADDR_BITS(PROG_ADDR_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_func(s_axis_tdata[5:0]), .i_reg_index(s_axis_tdata[13:6]),
        .i_operand(s_axis_tdata[77:14]), .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid), .o_next_ip(next_ip), .o_running(running),
        .o_top_value(top_value), .o_top_valid(top_valid), .o_error_code(error_code)
    );

    assign m_axis_tdata = {3'd0, error_code, top_valid, top_value, running, next_ip};
endmodule

// ===== tb/sv/testbench.sv =====
module testbench import ism_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_V = 64;
    localparam int DEPTH_R = 16;
    localparam int NREGS   = 16;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;

    // first member sits in the highest bits
    typedef struct packed {
        t_err        error_code;
        logic        top_valid;
        logic [63:0] top_value;
        logic        running;
        logic [15:0] next_ip;
    } t_outcome;

    typedef struct {
        t_op         op;
        logic [7:0]  ri;
        logic [63:0] opd;
        logic        has_exp;
        t_outcome    exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // func[5:0], reg_index[13:6], operand[77:14], zero[79:78]
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // next_ip[15:0], running[16], top_value[80:17], top_valid[81],
    // error_code[84:82], zero[87:85]
    logic [87:0] m_axis_tdata;

    integer_stack_machine_execute dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predictor state
    logic [15:0] pm_pc;
    logic [63:0] pm_vstk [DEPTH_V];
    int          pm_vcnt;
    logic [15:0] pm_rstk [DEPTH_R];
    int          pm_rcnt;
    logic [63:0] pm_regs [NREGS];
    logic        pm_halted;

    t_outcome pending_steps[$];
    int       errors;
    int       sent;
    int       received;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_recv;
    int       halts_seen;
    bit       op_seen[64];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] pow_wrap(logic [63:0] base, logic [63:0] e);
        logic [63:0] r;
        r = 64'd1;
        if (e[63] || e == 0) return 64'd1;
        while (e != 0) begin
            if (e[0]) r = r * base;
            base = base * base;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic t_outcome exec_instr(t_op op, logic [7:0] ri, logic [63:0] opd);
        t_outcome    o;
        logic [15:0] nip;
        logic [15:0] target;
        int          need;
        logic        grow;
        logic        reg_ok;
        logic        run;
        t_err        err;
        logic [63:0] a, b, r;
        nip = pm_pc + 16'd1;
        target = opd[15:0];
        need = 0;
        grow = 1'b0;
        reg_ok = ri < NREGS;
        run = 1'b1;
        err = ERR_NONE;
        a = '0;
        b = '0;
        r = '0;
        if (pm_halted) begin
            nip = pm_pc;
            run = 1'b0;
        end else begin
            case (op)
                OP_PUSH: grow = 1'b1;
                OP_POP, OP_JMP_IF, OP_INC, OP_ABS, OP_NOT: need = 1;
                OP_DUP: begin
                    need = 1;
                    grow = 1'b1;
                end
                OP_MOV_REG: need = reg_ok ? 1 : 0;
                OP_LOAD_REG: grow = reg_ok;
                OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LE, OP_GE, OP_ADD, OP_SUB, OP_MUL,
                OP_DIV, OP_MOD, OP_POW, OP_MIN, OP_MAX, OP_AND, OP_OR, OP_XOR,
                OP_SHL, OP_SHR: need = 2;
                default: ;
            endcase
            if (pm_vcnt < need) err = ERR_UNDERFLOW;
            else if (grow && pm_vcnt >= DEPTH_V) err = ERR_OVERFLOW;
            if (err == ERR_NONE && need == 2) begin
                b = pm_vstk[pm_vcnt-1];
                a = pm_vstk[pm_vcnt-2];
                if (op == OP_DIV && b == 0) err = ERR_DIV_ZERO;
                if (op == OP_MOD && b == 0) err = ERR_MOD_ZERO;
            end else if (err == ERR_NONE && need == 1) begin
                a = pm_vstk[pm_vcnt-1];
            end
            if (err == ERR_NONE && op == OP_CALL && pm_rcnt >= DEPTH_R) err = ERR_RET_OVERFLOW;
            if (err != ERR_NONE) begin
                pm_halted = 1'b1;
                run = 1'b0;
                nip = pm_pc;
            end else begin
                if (need == 2) begin
                    case (op)
                        OP_EQ:  r = 64'(a == b);
                        OP_NEQ: r = 64'(a != b);
                        OP_LT:  r = 64'($signed(a) < $signed(b));
                        OP_GT:  r = 64'($signed(a) > $signed(b));
                        OP_LE:  r = 64'($signed(a) <= $signed(b));
                        OP_GE:  r = 64'($signed(a) >= $signed(b));
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV: begin
                            if (a == MIN64 && b == '1) r = MIN64;
                            else r = $signed(a) / $signed(b);
                        end
                        OP_MOD: begin
                            if (a == MIN64 && b == '1) r = '0;
                            else r = $signed(a) % $signed(b);
                        end
                        OP_POW: r = pow_wrap(a, b);
                        OP_MIN: r = ($signed(b) < $signed(a)) ? b : a;
                        OP_MAX: r = ($signed(a) < $signed(b)) ? b : a;
                        OP_AND: r = a & b;
                        OP_OR:  r = a | b;
                        OP_XOR: r = a ^ b;
                        OP_SHL: r = (b >= 64) ? '0 : (a << b[5:0]);
                        default: r = (b >= 64) ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
                    endcase
                    pm_vcnt--;
                    pm_vstk[pm_vcnt-1] = r;
                end else begin
                    case (op)
                        OP_HALT: begin
                            run = 1'b0;
                            pm_halted = 1'b1;
                        end
                        OP_PUSH: begin
                            pm_vstk[pm_vcnt] = opd;
                            pm_vcnt++;
                        end
                        OP_POP: pm_vcnt--;
                        OP_DUP: begin
                            pm_vstk[pm_vcnt] = a;
                            pm_vcnt++;
                        end
                        OP_JMP: nip = target;
                        OP_JMP_IF: begin
                            pm_vcnt--;
                            if (a != 0) nip = target;
                        end
                        OP_MOV_REG: if (reg_ok) begin
                            pm_regs[ri] = a;
                            pm_vcnt--;
                        end
                        OP_LOAD_REG: if (reg_ok) begin
                            pm_vstk[pm_vcnt] = pm_regs[ri];
                            pm_vcnt++;
                        end
                        OP_INC: pm_vstk[pm_vcnt-1] = a + 1;
                        OP_ABS: pm_vstk[pm_vcnt-1] = a[63] ? -a : a;
                        OP_NOT: pm_vstk[pm_vcnt-1] = ~a;
                        OP_CALL: begin
                            pm_rstk[pm_rcnt] = nip;
                            pm_rcnt++;
                            nip = target;
                        end
                        OP_RET: begin
                            if (pm_rcnt == 0) begin
                                run = 1'b0;
                                pm_halted = 1'b1;
                            end else begin
                                pm_rcnt--;
                                nip = pm_rstk[pm_rcnt];
                            end
                        end
                        default: ;
                    endcase
                end
                pm_pc = nip;
            end
        end
        o.next_ip = nip;
        o.running = run;
        o.top_valid = pm_vcnt != 0;
        o.top_value = pm_vcnt != 0 ? pm_vstk[pm_vcnt-1] : '0;
        o.error_code = err;
        return o;
    endfunction

    // the block stays halted until reset, so the run halts it only once, at the end
    task automatic send_request(t_op op, logic [7:0] ri, logic [63:0] opd,
                                logic has_exp, t_outcome exp);
        t_outcome p;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, opd, ri, 6'(op)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = exec_instr(op, ri, opd);
        if (has_exp && p !== exp) begin
            $display("%0t table row disagrees: expected %h predicted %h", $time, exp, p);
            errors++;
        end
        pending_steps.insert(pending_steps.size(), p);
        op_seen[op] = 1'b1;
        sent++;
    endtask

    task automatic idle_sender;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain_results;
        int guard;
        guard = 0;
        while (pending_steps.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_recv > 0) begin
                hold_recv <= hold_recv - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                t_outcome got;
                t_outcome want;
                got = t_outcome'(m_axis_tdata[84:0]);
                received++;
                if (pending_steps.size() == 0) begin
                    $display("%0t unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = pending_steps.pop_front();
                    if (got.next_ip !== want.next_ip) begin
                        $display("%0t next_ip expected %h actual %h", $time,
                                 want.next_ip, got.next_ip);
                        errors++;
                    end
                    if (got.running !== want.running) begin
                        $display("%0t running expected %b actual %b", $time,
                                 want.running, got.running);
                        errors++;
                    end
                    if (got.top_value !== want.top_value) begin
                        $display("%0t top_value expected %h actual %h", $time,
                                 want.top_value, got.top_value);
                        errors++;
                    end
                    if (got.top_valid !== want.top_valid) begin
                        $display("%0t top_valid expected %b actual %b", $time,
                                 want.top_valid, got.top_valid);
                        errors++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $display("%0t error_code expected %0d actual %0d", $time,
                                 want.error_code, got.error_code);
                        errors++;
                    end
                    if (!want.running) halts_seen++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(5))
            0: return MIN64;
            1: return MAX64;
            2: return 64'($urandom_range(70)) - 64'd3;
            3: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_op pick_op();
        int k;
        k = $urandom_range(99);
        if (k < 30) return OP_PUSH;
        if (k < 34) return OP_DUP;
        if (k < 38) return OP_LOAD_REG;
        if (k < 42) return OP_MOV_REG;
        if (k < 45) return OP_CALL;
        if (k < 48) return OP_RET;
        if (k < 51) return OP_NOP;
        return t_op'(6'($urandom_range(OP_POP, OP_SHR)));
    endfunction

    // random step that keeps the machine alive; with any_op set the stack safety check is skipped
    task automatic random_step(bit any_op);
        t_op         op;
        logic [7:0]  ri;
        logic [63:0] opd;
        int          tries;
        tries = 0;
        do begin
            op = any_op ? t_op'(6'($urandom_range(63))) : pick_op();
            ri = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(NREGS - 1));
            opd = rand64();
            if (op inside {OP_DIV, OP_MOD} && pm_vcnt >= 2 && pm_vstk[pm_vcnt-1] == 0)
                op = OP_ADD;
            if (op == OP_HALT) op = OP_NOP;
            if (op == OP_RET && pm_rcnt == 0) op = OP_NOP;
            if (op == OP_CALL && pm_rcnt >= DEPTH_R) op = OP_RET;
            if (op inside {OP_POW, OP_SHL, OP_SHR} && pm_vcnt >= 2 && $urandom_range(1))
                pm_vstk[pm_vcnt-1] = pm_vstk[pm_vcnt-1];
            tries++;
        end while (tries < 20 && !any_op && !step_is_safe(op, ri));
        if (!any_op && !step_is_safe(op, ri)) op = (pm_vcnt < DEPTH_V) ? OP_PUSH : OP_POP;
        send_request(op, ri, opd, 1'b0, '0);
    endtask

    function automatic bit step_is_safe(t_op op, logic [7:0] ri);
        int need;
        bit grow;
        need = 0;
        grow = 0;
        case (op)
            OP_PUSH: grow = 1;
            OP_DUP: begin
                need = 1;
                grow = 1;
            end
            OP_LOAD_REG: grow = ri < NREGS;
            OP_MOV_REG: need = ri < NREGS;
            OP_POP, OP_JMP_IF, OP_INC, OP_ABS, OP_NOT: need = 1;
            OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_LE, OP_GE, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
            OP_MOD, OP_POW, OP_MIN, OP_MAX, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:
                need = 2;
            default: ;
        endcase
        return pm_vcnt >= need && !(grow && pm_vcnt >= DEPTH_V);
    endfunction

    t_row dir_rows[$];

    function automatic t_outcome mk(logic [15:0] ip, logic run, logic [63:0] tv,
                                    logic vld, t_err e);
        t_outcome o;
        o.next_ip = ip;
        o.running = run;
        o.top_value = tv;
        o.top_valid = vld;
        o.error_code = e;
        return o;
    endfunction

    function automatic t_row row(t_op op, logic [7:0] ri, logic [63:0] opd);
        t_row r;
        r.op = op;
        r.ri = ri;
        r.opd = opd;
        r.has_exp = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_row row_x(t_op op, logic [7:0] ri, logic [63:0] opd, t_outcome e);
        t_row r;
        r = row(op, ri, opd);
        r.has_exp = 1'b1;
        r.exp = e;
        return r;
    endfunction

    initial begin
        dir_rows = '{
            row_x(OP_NOP, 8'd0, '0, mk(16'd1, 1'b1, '0, 1'b0, ERR_NONE)),
            row_x(OP_PUSH, 8'hff, MIN64, mk(16'd2, 1'b1, MIN64, 1'b1, ERR_NONE)),
            row(OP_PUSH, 8'd0, '1),
            row_x(OP_DIV, 8'd0, '0, mk(16'd4, 1'b1, MIN64, 1'b1, ERR_NONE)),
            row_x(OP_ABS, 8'd0, '0, mk(16'd5, 1'b1, MIN64, 1'b1, ERR_NONE)),
            row(OP_PUSH, 8'd0, '1),
            row_x(OP_MOD, 8'd0, '0, mk(16'd7, 1'b1, '0, 1'b1, ERR_NONE)),
            row(OP_PUSH, 8'd0, MAX64),
            row(OP_PUSH, 8'd0, 64'd64),
            row_x(OP_SHL, 8'd0, '0, mk(16'd10, 1'b1, '0, 1'b1, ERR_NONE)),
            row(OP_PUSH, 8'd0, MIN64),
            row(OP_PUSH, 8'd0, '1),
            row_x(OP_SHR, 8'd0, '0, mk(16'd13, 1'b1, '1, 1'b1, ERR_NONE)),
            row(OP_PUSH, 8'd0, 64'd3),
            row(OP_PUSH, 8'd0, -64'sd2),
            row_x(OP_POW, 8'd0, '0, mk(16'd16, 1'b1, 64'd1, 1'b1, ERR_NONE)),
            row(OP_MOV_REG, 8'd15, '0),
            row(OP_LOAD_REG, 8'd16, '0),
            row(OP_LOAD_REG, 8'd15, '0),
            row(OP_CALL, 8'd0, 64'hffff_ffff_ffff_ffff),
            row(OP_RET, 8'd0, '0),
            row(OP_JMP, 8'd0, 64'h1234_0000_0000_ffff),
            row(OP_JMP_IF, 8'd0, 64'h0000_0000_0000_0040),
            row(OP_PUSH, 8'd0, '0)
        };
    end

    initial begin
        logic [63:0] walk;
        int          ops_covered;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        errors = 0;
        sent = 0;
        received = 0;
        halts_seen = 0;
        hold_recv = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pm_pc = '0;
        pm_vcnt = 0;
        pm_rcnt = 0;
        pm_halted = 1'b0;
        for (int i = 0; i < NREGS; i++) pm_regs[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].op, dir_rows[i].ri, dir_rows[i].opd,
                         dir_rows[i].has_exp, dir_rows[i].exp);

        // walk every operand bit through both values, and fill the stack
        for (int i = 0; i < 64; i++) begin
            walk = 64'd1 << i;
            if (pm_vcnt >= DEPTH_V) send_request(OP_POP, 8'd0, '0, 1'b0, '0);
            send_request(OP_PUSH, 8'($urandom), (i % 2) ? ~walk : walk, 1'b0, '0);
        end
        // fill the return stack to the top
        while (pm_rcnt < DEPTH_R)
            send_request(OP_CALL, 8'd0, {$urandom, $urandom}, 1'b0, '0);
        send_request(OP_RET, 8'd0, '0, 1'b0, '0);

        // long receiver hold-off while requests keep coming
        hold_recv = 300;
        for (int i = 0; i < 40; i++) random_step(0);
        idle_sender();
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 78;
                end
                default: begin
                    send_idle_pct = 38;
                    recv_stall_pct = 38;
                end
            endcase
            for (int i = 0; i < 170; i++) random_step(0);
        end
        // underflow fault on purpose: pop the stack empty, then one more
        while (pm_vcnt > 0) send_request(OP_POP, 8'd0, '0, 1'b0, '0);
        send_request(OP_POP, 8'd0, '0, 1'b1, mk(pm_pc, 1'b0, '0, 1'b0, ERR_UNDERFLOW));
        // halted machine reports the held counter
        for (int i = 0; i < 6; i++) random_step(1);
        idle_sender();
        drain_results();
        repeat (200) @(posedge i_clk);

        ops_covered = 0;
        foreach (op_seen[k]) if (op_seen[k]) ops_covered++;
        $display("%0d requests sent and %0d results checked over the idle and stall phases",
                 sent, received);
        $display("%0d distinct opcodes exercised, %0d results from a stopped machine",
                 ops_covered, halts_seen);
        if (errors == 0 && pending_steps.size() == 0) begin
            $display("integer_stack_machine_execute regression: pass");
        end else begin
            $display("integer_stack_machine_execute regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("integer_stack_machine_execute regression: fail");
        $finish;
    end

endmodule
